### rtl/acsc_pkg.sv
package acsc_pkg;

  // Field widths
  localparam int CH_W       = 3;
  localparam int SAMPLE_W   = 12;
  localparam int ACC_W      = 16;
  localparam int SCALED_W   = 16;
  localparam int VGAIN_W    = 13;
  localparam int CGAIN_W    = 8;
  localparam int OFFSET_W   = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 13;

  // Parameter defaults
  localparam int CHANNELS_DEF        = 8;
  localparam int FILTER_ORDER_DEF    = 4;
  localparam int PRECISION_SHIFT_DEF = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_CH    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_CH     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_CH     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ARRAY_GAIN  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BATT_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_GAIN   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_CURR_OFFSET = 3'd6;

  // Configuration reset values
  localparam logic [CH_W-1:0]     RST_ARRAY_CH    = 3'd0;
  localparam logic [CH_W-1:0]     RST_BATT_CH     = 3'd1;
  localparam logic [CH_W-1:0]     RST_CURR_CH     = 3'd2;
  localparam logic [VGAIN_W-1:0]  RST_ARRAY_GAIN  = 13'd4400;
  localparam logic [VGAIN_W-1:0]  RST_BATT_GAIN   = 13'd1888;
  localparam logic [CGAIN_W-1:0]  RST_CURR_GAIN   = 8'd40;
  localparam logic [OFFSET_W-1:0] RST_CURR_OFFSET = 12'h170;

  // Channel scaling kinds
  localparam logic [1:0] KIND_NONE  = 2'd0;
  localparam logic [1:0] KIND_ARRAY = 2'd1;
  localparam logic [1:0] KIND_BATT  = 2'd2;
  localparam logic [1:0] KIND_CURR  = 2'd3;

  // Scaling product and reciprocal division constants.
  // floor(x/D) = (x*M) >> K is exact for x < 2**PROD_W with K = PROD_W + clog2(D).
  localparam int PROD_W   = ACC_W + VGAIN_W;
  localparam int VOLT_DIV = 1000;
  localparam int CURR_DIV = 100;
  localparam int VOLT_SH  = PROD_W + $clog2(VOLT_DIV);
  localparam int CURR_SH  = PROD_W + $clog2(CURR_DIV);
  localparam int RECIP_W  = 30;
  localparam logic [63:0] VOLT_RECIP64 =
    ((64'd1 << VOLT_SH) + 64'(VOLT_DIV) - 64'd1) / 64'(VOLT_DIV);
  localparam logic [63:0] CURR_RECIP64 =
    ((64'd1 << CURR_SH) + 64'(CURR_DIV) - 64'd1) / 64'(CURR_DIV);
  localparam logic [RECIP_W-1:0] VOLT_RECIP = VOLT_RECIP64[RECIP_W-1:0];
  localparam logic [RECIP_W-1:0] CURR_RECIP = CURR_RECIP64[RECIP_W-1:0];
  localparam int RPROD_W = PROD_W + RECIP_W;

  localparam logic [SCALED_W-1:0] SAT_MAX = '1;

  // Accumulator bank request and response
  typedef struct packed {
    logic                we;
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } acc_req_t;

  typedef struct packed {
    logic             in_range;
    logic [ACC_W-1:0] acc;
  } acc_rsp_t;

endpackage

### rtl/acsc_stream_if.sv
interface acsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [acsc_pkg::CH_W-1:0]     channel;
  logic [acsc_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output channel, output sample, input ready);
  modport sink (input valid, input channel, input sample, output ready);
endinterface

interface acsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [acsc_pkg::CH_W-1:0]     channel_out;
  logic [acsc_pkg::ACC_W-1:0]    filtered;
  logic [acsc_pkg::SCALED_W-1:0] scaled;
  logic                          scaled_valid;

  modport source (output valid, output channel_out, output filtered, output scaled,
                  output scaled_valid, input ready);
  modport sink (input valid, input channel_out, input filtered, input scaled,
                input scaled_valid, output ready);
endinterface

### rtl/acsc_acc_bank.sv
module acsc_acc_bank #(
  parameter int CHANNELS        = acsc_pkg::CHANNELS_DEF,
  parameter int FILTER_ORDER    = acsc_pkg::FILTER_ORDER_DEF,
  parameter int PRECISION_SHIFT = acsc_pkg::PRECISION_SHIFT_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  acsc_pkg::acc_req_t req,
  output acsc_pkg::acc_rsp_t rsp
);

  localparam int ACC_W  = acsc_pkg::ACC_W;
  localparam int EXT_W  = ACC_W + 1;
  localparam int IDXW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int WW     = (IDXW > acsc_pkg::CH_W) ? IDXW : acsc_pkg::CH_W;
  // floor(x/N) = (x*M) >> K, exact for x < 2**EXT_W
  localparam int LOG_N  = $clog2(FILTER_ORDER);
  localparam int DIV_SH = EXT_W + LOG_N;
  localparam int DIV_MW = DIV_SH + 1 - LOG_N;
  localparam int DIV_PW = EXT_W + DIV_MW;
  localparam logic [63:0] DIV_M64 =
    ((64'd1 << DIV_SH) + 64'(FILTER_ORDER) - 64'd1) / 64'(FILTER_ORDER);
  localparam logic [DIV_MW-1:0] DIV_M = DIV_M64[DIV_MW-1:0];

  logic [ACC_W-1:0]  acc_r [CHANNELS];
  logic [WW-1:0]     ch_w;
  logic [IDXW-1:0]   idx;
  logic              in_range;
  logic [ACC_W-1:0]  acc_rd;
  logic [EXT_W-1:0]  acc_up;
  logic [EXT_W-1:0]  smp_ext;
  logic [DIV_PW-1:0] prod_up;
  logic [DIV_PW-1:0] prod_smp;
  logic [EXT_W-1:0]  ceil_q;
  logic [EXT_W-1:0]  smp_q;
  logic [EXT_W-1:0]  sum;
  logic [ACC_W-1:0]  acc_new;

  assign ch_w     = WW'(req.channel);
  assign idx      = ch_w[IDXW-1:0];
  assign in_range = (32'(req.channel) < 32'(CHANNELS));
  assign acc_rd   = in_range ? acc_r[idx] : '0;

  // acc*(N-1)/N floored equals acc - ceil(acc/N)
  assign acc_up   = {1'b0, acc_rd} + EXT_W'(FILTER_ORDER - 1);
  assign smp_ext  = EXT_W'(req.sample) << PRECISION_SHIFT;
  assign prod_up  = DIV_PW'(acc_up) * DIV_PW'(DIV_M);
  assign prod_smp = DIV_PW'(smp_ext) * DIV_PW'(DIV_M);
  assign ceil_q   = EXT_W'(prod_up >> DIV_SH);
  assign smp_q    = EXT_W'(prod_smp >> DIV_SH);
  assign sum      = {1'b0, acc_rd} - ceil_q + smp_q;
  assign acc_new  = sum[ACC_W] ? '1 : sum[ACC_W-1:0];

  assign rsp.in_range = in_range;
  assign rsp.acc      = in_range ? acc_new : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        acc_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < CHANNELS; i++) begin
        if (req.we && in_range && (idx == IDXW'(i))) begin
          acc_r[i] <= acc_new;
        end
      end
    end
  end

endmodule

### rtl/adc_channel_smoothing_scaler.sv
// Result path: input register (stage 1), stage 2, stage 3, then the output register.
// Throughput: one item per cycle unless stalled; the per-channel accumulator update
//   closes in the first stage, so items on the same channel may follow back to back.
// Reset (rst_n, synchronous, active low): all accumulators cleared at once, config
//   registers return to their defaults, the pipeline empties. No clearing pass.
module adc_channel_smoothing_scaler #(
  parameter int CHANNELS        = acsc_pkg::CHANNELS_DEF,
  parameter int FILTER_ORDER    = acsc_pkg::FILTER_ORDER_DEF,
  parameter int PRECISION_SHIFT = acsc_pkg::PRECISION_SHIFT_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  acsc_in_if.sink                         in_if,
  acsc_out_if.source                      out_if,
  input  logic                            cfg_we,
  input  logic [acsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [acsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int CH_W     = acsc_pkg::CH_W;
  localparam int ACC_W    = acsc_pkg::ACC_W;
  localparam int SAMPLE_W = acsc_pkg::SAMPLE_W;
  localparam int PROD_W   = acsc_pkg::PROD_W;
  localparam int RPROD_W  = acsc_pkg::RPROD_W;
  localparam int VGAIN_W  = acsc_pkg::VGAIN_W;

  // ---------------------------------------------------------------------------
  // Configuration registers, unguarded; user writes only while the pipeline is idle
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]               cfg_array_ch_r;
  logic [CH_W-1:0]               cfg_batt_ch_r;
  logic [CH_W-1:0]               cfg_curr_ch_r;
  logic [VGAIN_W-1:0]            cfg_array_gain_r;
  logic [VGAIN_W-1:0]            cfg_batt_gain_r;
  logic [acsc_pkg::CGAIN_W-1:0]  cfg_curr_gain_r;
  logic [acsc_pkg::OFFSET_W-1:0] cfg_curr_offset_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_array_ch_r    <= acsc_pkg::RST_ARRAY_CH;
      cfg_batt_ch_r     <= acsc_pkg::RST_BATT_CH;
      cfg_curr_ch_r     <= acsc_pkg::RST_CURR_CH;
      cfg_array_gain_r  <= acsc_pkg::RST_ARRAY_GAIN;
      cfg_batt_gain_r   <= acsc_pkg::RST_BATT_GAIN;
      cfg_curr_gain_r   <= acsc_pkg::RST_CURR_GAIN;
      cfg_curr_offset_r <= acsc_pkg::RST_CURR_OFFSET;
    end else if (cfg_we) begin
      case (cfg_index)
        acsc_pkg::CFG_ARRAY_CH:    cfg_array_ch_r    <= cfg_wdata[CH_W-1:0];
        acsc_pkg::CFG_BATT_CH:     cfg_batt_ch_r     <= cfg_wdata[CH_W-1:0];
        acsc_pkg::CFG_CURR_CH:     cfg_curr_ch_r     <= cfg_wdata[CH_W-1:0];
        acsc_pkg::CFG_ARRAY_GAIN:  cfg_array_gain_r  <= cfg_wdata[VGAIN_W-1:0];
        acsc_pkg::CFG_BATT_GAIN:   cfg_batt_gain_r   <= cfg_wdata[VGAIN_W-1:0];
        acsc_pkg::CFG_CURR_GAIN:   cfg_curr_gain_r   <= cfg_wdata[acsc_pkg::CGAIN_W-1:0];
        acsc_pkg::CFG_CURR_OFFSET: cfg_curr_offset_r <= cfg_wdata[acsc_pkg::OFFSET_W-1:0];
        default: ; // drop writes past the last register
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: each stage advances when the next one is empty or
  // moving. Ready runs back combinationally from the output register.
  // ---------------------------------------------------------------------------
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic s1_v_nxt, s2_v_nxt, s3_v_nxt, out_v_nxt;
  logic s1_adv, s2_adv, s3_adv;
  logic in_xfer;

  assign s3_adv  = s3_v_r && (!out_v_r || out_if.ready);
  assign s2_adv  = s2_v_r && (!s3_v_r || s3_adv);
  assign s1_adv  = s1_v_r && (!s2_v_r || s2_adv);
  assign in_if.ready = !s1_v_r || s1_adv;
  assign in_xfer = in_if.valid && in_if.ready;

  always_comb begin
    s1_v_nxt  = in_xfer ? 1'b1 : (s1_adv ? 1'b0 : s1_v_r);
    s2_v_nxt  = s1_adv  ? 1'b1 : (s2_adv ? 1'b0 : s2_v_r);
    s3_v_nxt  = s2_adv  ? 1'b1 : (s3_adv ? 1'b0 : s3_v_r);
    out_v_nxt = s3_adv  ? 1'b1 : (out_if.ready ? 1'b0 : out_v_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      s1_v_r  <= s1_v_nxt;
      s2_v_r  <= s2_v_nxt;
      s3_v_r  <= s3_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: input register, accumulator read-modify-write, channel match
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]     s1_ch_r;
  logic [SAMPLE_W-1:0] s1_sample_r;

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_ch_r     <= in_if.channel;
      s1_sample_r <= in_if.sample;
    end
  end

  acsc_pkg::acc_req_t acc_req;
  acsc_pkg::acc_rsp_t acc_rsp;

  // Commit the accumulator exactly when the item leaves stage 1
  assign acc_req.we      = s1_adv;
  assign acc_req.channel = s1_ch_r;
  assign acc_req.sample  = s1_sample_r;

  acsc_acc_bank #(
    .CHANNELS        (CHANNELS),
    .FILTER_ORDER    (FILTER_ORDER),
    .PRECISION_SHIFT (PRECISION_SHIFT)
  ) u_acc_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (acc_req),
    .rsp   (acc_rsp)
  );

  // Array voltage wins over battery voltage, which wins over battery current
  logic [1:0] s1_kind;
  always_comb begin
    if (!acc_rsp.in_range) begin
      s1_kind = acsc_pkg::KIND_NONE;
    end else if (s1_ch_r == cfg_array_ch_r) begin
      s1_kind = acsc_pkg::KIND_ARRAY;
    end else if (s1_ch_r == cfg_batt_ch_r) begin
      s1_kind = acsc_pkg::KIND_BATT;
    end else if (s1_ch_r == cfg_curr_ch_r) begin
      s1_kind = acsc_pkg::KIND_CURR;
    end else begin
      s1_kind = acsc_pkg::KIND_NONE;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: select operand and gain, multiply
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]  s2_ch_r;
  logic [ACC_W-1:0] s2_filt_r;
  logic [1:0]       s2_kind_r;

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_ch_r   <= s1_ch_r;
      s2_filt_r <= acc_rsp.acc;
      s2_kind_r <= s1_kind;
    end
  end

  logic [ACC_W-1:0]   s2_v;
  logic [ACC_W-1:0]   s2_op;
  logic [VGAIN_W-1:0] s2_gain;
  logic [PROD_W-1:0]  s2_prod;

  assign s2_v = s2_filt_r >> PRECISION_SHIFT;

  always_comb begin
    case (s2_kind_r)
      acsc_pkg::KIND_ARRAY: begin
        s2_op   = s2_v;
        s2_gain = cfg_array_gain_r;
      end
      acsc_pkg::KIND_BATT: begin
        s2_op   = s2_v;
        s2_gain = cfg_batt_gain_r;
      end
      acsc_pkg::KIND_CURR: begin
        // Readings at or below the zero-current point clamp to zero
        s2_op   = (s2_v > ACC_W'(cfg_curr_offset_r)) ?
                  (s2_v - ACC_W'(cfg_curr_offset_r)) : '0;
        s2_gain = VGAIN_W'(cfg_curr_gain_r);
      end
      default: begin
        s2_op   = '0;
        s2_gain = '0;
      end
    endcase
  end

  assign s2_prod = PROD_W'(s2_op) * PROD_W'(s2_gain);

  // ---------------------------------------------------------------------------
  // Stage 3: divide by 1000 or 100 through a reciprocal, saturate
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]   s3_ch_r;
  logic [ACC_W-1:0]  s3_filt_r;
  logic [1:0]        s3_kind_r;
  logic [PROD_W-1:0] s3_prod_r;

  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s3_ch_r   <= s2_ch_r;
      s3_filt_r <= s2_filt_r;
      s3_kind_r <= s2_kind_r;
      s3_prod_r <= s2_prod;
    end
  end

  logic [RPROD_W-1:0]             s3_vprod;
  logic [RPROD_W-1:0]             s3_cprod;
  logic [PROD_W-1:0]              s3_quot;
  logic [acsc_pkg::SCALED_W-1:0]  s3_scaled;

  assign s3_vprod = RPROD_W'(s3_prod_r) * RPROD_W'(acsc_pkg::VOLT_RECIP);
  assign s3_cprod = RPROD_W'(s3_prod_r) * RPROD_W'(acsc_pkg::CURR_RECIP);

  always_comb begin
    case (s3_kind_r)
      acsc_pkg::KIND_ARRAY, acsc_pkg::KIND_BATT:
        s3_quot = PROD_W'(s3_vprod >> acsc_pkg::VOLT_SH);
      acsc_pkg::KIND_CURR:
        s3_quot = PROD_W'(s3_cprod >> acsc_pkg::CURR_SH);
      default:
        s3_quot = '0;
    endcase
    s3_scaled = (s3_quot > PROD_W'(acsc_pkg::SAT_MAX)) ?
                acsc_pkg::SAT_MAX : s3_quot[acsc_pkg::SCALED_W-1:0];
  end

  // ---------------------------------------------------------------------------
  // Output register: hold while the sink stalls
  // ---------------------------------------------------------------------------
  logic [CH_W-1:0]               out_ch_r;
  logic [ACC_W-1:0]              out_filt_r;
  logic [acsc_pkg::SCALED_W-1:0] out_scaled_r;
  logic                          out_svalid_r;

  always_ff @(posedge clk) begin
    if (s3_adv) begin
      out_ch_r     <= s3_ch_r;
      out_filt_r   <= s3_filt_r;
      out_scaled_r <= s3_scaled;
      out_svalid_r <= (s3_kind_r != acsc_pkg::KIND_NONE);
    end
  end

  assign out_if.valid        = out_v_r;
  assign out_if.channel_out  = out_ch_r;
  assign out_if.filtered     = out_filt_r;
  assign out_if.scaled       = out_scaled_r;
  assign out_if.scaled_valid = out_svalid_r;

endmodule

### rtl/acsc_checker.sv
module acsc_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [acsc_pkg::CH_W-1:0]       out_channel_out,
  input logic [acsc_pkg::ACC_W-1:0]      out_filtered,
  input logic [acsc_pkg::SCALED_W-1:0]   out_scaled,
  input logic                            out_scaled_valid
);

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_channel_out) && $stable(out_filtered)
                                && $stable(out_scaled) && $stable(out_scaled_valid))
    else $error("stalled result changed");

  // Unscaled channels report zero
  a_unscaled_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_scaled_valid |-> out_scaled == '0)
    else $error("scaled nonzero without scaled_valid");

  // With the sink always ready, each transfer reaches the output register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && out_ready) ##1 out_ready ##1 out_ready ##1 out_ready
    |=> out_valid)
    else $error("result missing after pipeline latency");

endmodule

bind adc_channel_smoothing_scaler acsc_checker u_acsc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_channel_out  (out_if.channel_out),
  .out_filtered     (out_if.filtered),
  .out_scaled       (out_if.scaled),
  .out_scaled_valid (out_if.scaled_valid)
);

### tb/sv/tb_top.sv
module tb_top;

  localparam int CHANNELS        = acsc_pkg::CHANNELS_DEF;
  localparam int FILTER_ORDER    = acsc_pkg::FILTER_ORDER_DEF;
  localparam int PRECISION_SHIFT = acsc_pkg::PRECISION_SHIFT_DEF;

  localparam int CH_W       = acsc_pkg::CH_W;
  localparam int SAMPLE_W   = acsc_pkg::SAMPLE_W;
  localparam int ACC_W      = acsc_pkg::ACC_W;
  localparam int SCALED_W   = acsc_pkg::SCALED_W;
  localparam int CFG_IDX_W  = acsc_pkg::CFG_IDX_W;
  localparam int CFG_DATA_W = acsc_pkg::CFG_DATA_W;
  localparam int VGAIN_W    = acsc_pkg::VGAIN_W;
  localparam int CGAIN_W    = acsc_pkg::CGAIN_W;
  localparam int OFFSET_W   = acsc_pkg::OFFSET_W;

  // Scaling divisors and the saturation ceiling of every 16-bit result
  localparam longint unsigned VOLT_DIVISOR = 1000;
  localparam longint unsigned CURR_DIVISOR = 100;
  localparam longint unsigned SAT16        = 65535;

  localparam logic [SAMPLE_W-1:0]  SAMPLE_MAX    = '1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_IDX = 3'd7;

  // Pipeline holds up to 4 items; give it ample room to flush before a register
  // write or the end
  localparam int DRAIN_CYCLES   = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_PHASES  = 8;
  localparam int PHASE_ITEMS    = 112;

  typedef struct packed {
    logic [CH_W-1:0]     channel;
    logic [SAMPLE_W-1:0] sample;
  } sample_item_t;

  typedef struct packed {
    logic [CH_W-1:0]     channel_out;
    logic [ACC_W-1:0]    filtered;
    logic [SCALED_W-1:0] scaled;
    logic                scaled_valid;
  } reading_t;

  // Receiver ready patterns
  typedef enum int {RX_ALWAYS, RX_RANDOM, RX_SPARSE, RX_BLOCKS} rx_mode_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  acsc_in_if  in_ch ();
  acsc_out_if out_ch ();

  adc_channel_smoothing_scaler #(
    .CHANNELS       (CHANNELS),
    .FILTER_ORDER   (FILTER_ORDER),
    .PRECISION_SHIFT(PRECISION_SHIFT)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_ch),
    .out_if   (out_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the block's registers and per-channel accumulators
  logic [CH_W-1:0]     arr_ch      = acsc_pkg::RST_ARRAY_CH;
  logic [CH_W-1:0]     batt_ch     = acsc_pkg::RST_BATT_CH;
  logic [CH_W-1:0]     curr_ch     = acsc_pkg::RST_CURR_CH;
  logic [VGAIN_W-1:0]  arr_gain    = acsc_pkg::RST_ARRAY_GAIN;
  logic [VGAIN_W-1:0]  batt_gain   = acsc_pkg::RST_BATT_GAIN;
  logic [CGAIN_W-1:0]  curr_gain   = acsc_pkg::RST_CURR_GAIN;
  logic [OFFSET_W-1:0] curr_offset = acsc_pkg::RST_CURR_OFFSET;
  logic [ACC_W-1:0]    acc_bank [CHANNELS];

  sample_item_t sample_queue [$];
  reading_t     expected_readings [$];

  int mismatch_count = 0;
  int idle_cycles    = 0;

  // Sender burst state, receiver pattern state
  int           burst_left = 1;
  int           gap_left   = 0;
  sample_item_t next_item;
  int           ready_cyc  = 0;
  rx_mode_t     ready_mode = RX_ALWAYS;
  reading_t     want;

  // Advance one channel's leaky average and derive its engineering value.
  function automatic reading_t filter_and_scale(sample_item_t it);
    reading_t        r;
    longint unsigned acc;
    longint unsigned level;
    longint unsigned prod;
    r = '0;
    prod = 0;
    r.channel_out = it.channel;
    if (it.channel < CHANNELS) begin
      // Form both terms at full width, truncate each, then saturate the sum
      acc = 64'(acc_bank[it.channel]) * (FILTER_ORDER - 1) / FILTER_ORDER
          + (64'(it.sample) << PRECISION_SHIFT) / FILTER_ORDER;
      if (acc > SAT16) acc = SAT16;
      acc_bank[it.channel] = ACC_W'(acc);
      r.filtered = ACC_W'(acc);
      level = acc >> PRECISION_SHIFT;
      // Array voltage wins over battery voltage, which wins over current
      if (it.channel == arr_ch) begin
        prod = level * arr_gain / VOLT_DIVISOR;
        r.scaled_valid = 1'b1;
      end else if (it.channel == batt_ch) begin
        prod = level * batt_gain / VOLT_DIVISOR;
        r.scaled_valid = 1'b1;
      end else if (it.channel == curr_ch) begin
        // Clamp readings at or below the zero-current offset to zero
        if (level > curr_offset) prod = (level - curr_offset) * curr_gain / CURR_DIVISOR;
        r.scaled_valid = 1'b1;
      end
      r.scaled = SCALED_W'((prod > SAT16) ? SAT16 : prod);
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      mismatch_count++;
    end
  endfunction

  task automatic push_item(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] s);
    sample_queue.push_back('{channel: ch, sample: s});
  endtask

  // Drive one register write and mirror it in the shadow copy.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    case (idx)
      acsc_pkg::CFG_ARRAY_CH:    arr_ch      = data[CH_W-1:0];
      acsc_pkg::CFG_BATT_CH:     batt_ch     = data[CH_W-1:0];
      acsc_pkg::CFG_CURR_CH:     curr_ch     = data[CH_W-1:0];
      acsc_pkg::CFG_ARRAY_GAIN:  arr_gain    = data[VGAIN_W-1:0];
      acsc_pkg::CFG_BATT_GAIN:   batt_gain   = data[VGAIN_W-1:0];
      acsc_pkg::CFG_CURR_GAIN:   curr_gain   = data[CGAIN_W-1:0];
      acsc_pkg::CFG_CURR_OFFSET: curr_offset = data[OFFSET_W-1:0];
      default: ;
    endcase
  endtask

  // Load a full register set. Fill the unused upper data bits with noise so the
  // block must mask them, and poke the unmapped index, which must change nothing.
  task automatic apply_setting(logic [CH_W-1:0] a_ch, logic [CH_W-1:0] b_ch,
                               logic [CH_W-1:0] c_ch, logic [VGAIN_W-1:0] a_gain,
                               logic [VGAIN_W-1:0] b_gain, logic [CGAIN_W-1:0] c_gain,
                               logic [OFFSET_W-1:0] offset);
    write_reg(CFG_SPARE_IDX, CFG_DATA_W'($urandom));
    write_reg(acsc_pkg::CFG_ARRAY_CH, {10'($urandom), a_ch});
    write_reg(acsc_pkg::CFG_BATT_CH, {10'($urandom), b_ch});
    write_reg(acsc_pkg::CFG_CURR_CH, {10'($urandom), c_ch});
    write_reg(acsc_pkg::CFG_ARRAY_GAIN, a_gain);
    write_reg(acsc_pkg::CFG_BATT_GAIN, b_gain);
    write_reg(acsc_pkg::CFG_CURR_GAIN, {5'($urandom), c_gain});
    write_reg(acsc_pkg::CFG_CURR_OFFSET, {1'($urandom), offset});
    @(posedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Hold until every queued item has transferred and every result has come back,
  // then let the pipeline settle.
  task automatic wait_drained();
    while (sample_queue.size() != 0 || in_ch.valid || expected_readings.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Half the runs hold one channel near a steady level so its accumulator
  // climbs to its limit and crosses the current offset; the rest vary channels.
  task automatic add_random_items(int count);
    int                  left;
    int                  run;
    logic [CH_W-1:0]     ch;
    logic [SAMPLE_W-1:0] level;
    left = count;
    while (left > 0) begin
      run = $urandom_range(1, 16);
      if (run > left) run = left;
      ch = CH_W'($urandom_range(0, CHANNELS - 1));
      if ($urandom_range(0, 3) == 0) level = $urandom_range(0, 1) ? SAMPLE_MAX : '0;
      else level = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
      case ($urandom_range(0, 3))
        0, 1: repeat (run) push_item(ch, level ^ SAMPLE_W'($urandom_range(0, 7)));
        2: repeat (run) push_item(CH_W'($urandom_range(0, CHANNELS - 1)),
                                  SAMPLE_W'($urandom_range(0, SAMPLE_MAX)));
        default: repeat (run) push_item(CH_W'($urandom_range(0, CHANNELS - 1)), level);
      endcase
      left -= run;
    end
  endtask

  // Sender: advance when the slot is free, drop valid during gaps, hold the item
  // while the block stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_ch.ready) begin
      if (gap_left > 0) begin
        gap_left = gap_left - 1;
        in_ch.valid <= 1'b0;
      end else if (sample_queue.size() != 0) begin
        next_item = sample_queue.pop_front();
        in_ch.valid   <= 1'b1;
        in_ch.channel <= next_item.channel;
        in_ch.sample  <= next_item.sample;
        burst_left = burst_left - 1;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Receiver: switch between the ready patterns at random.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      ready_cyc++;
      if (ready_cyc % 48 == 0) ready_mode = rx_mode_t'($urandom_range(0, 3));
      case (ready_mode)
        RX_ALWAYS: out_ch.ready <= 1'b1;
        RX_RANDOM: out_ch.ready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_ch.ready <= (ready_cyc % 5 != 0);
        default:   out_ch.ready <= ((ready_cyc / 8) % 2 == 1);
      endcase
    end
  end

  // Predict on every input transfer, check every output transfer against the
  // oldest prediction.
  always @(posedge clk) begin
    if (rst_n && in_ch.valid && in_ch.ready)
      expected_readings.push_back(filter_and_scale('{channel: in_ch.channel,
                                                     sample: in_ch.sample}));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_readings.size() == 0) begin
        $error("unexpected result: channel_out %0d, filtered %0d",
               out_ch.channel_out, out_ch.filtered);
        mismatch_count++;
      end else begin
        want = expected_readings.pop_front();
        check_field("channel_out", 32'(want.channel_out), 32'(out_ch.channel_out));
        check_field("filtered", 32'(want.filtered), 32'(out_ch.filtered));
        check_field("scaled", 32'(want.scaled), 32'(out_ch.scaled));
        check_field("scaled_valid", 32'(want.scaled_valid), 32'(out_ch.scaled_valid));
      end
    end
  end

  // Watchdog: end the run when nothing transfers for too long.
  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
      idle_cycles = 0;
    else
      idle_cycles = idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("adc_channel_smoothing_scaler: mismatch");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < CHANNELS; i++) acc_bank[i] = '0;
    in_ch.valid   = 1'b0;
    in_ch.channel = '0;
    in_ch.sample  = '0;
    out_ch.ready  = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset register values: current below its offset clamps to zero, then
    // climbs past it; full-scale samples on every channel, scaled or not, and zero samples on channels 2 and 7.
    push_item(3'd2, '0);
    for (int i = 0; i < CHANNELS; i++) push_item(CH_W'(i), SAMPLE_MAX);
    push_item(3'd7, '0);
    push_item(3'd0, SAMPLE_MAX);
    repeat (5) push_item(3'd2, SAMPLE_MAX);
    wait_drained();

    // All three roles on one channel at the largest gains: array voltage wins.
    apply_setting(3'd5, 3'd5, 3'd5, '1, '1, '1, '0);
    repeat (3) push_item(3'd5, SAMPLE_MAX);
    push_item(3'd5, '0);
    wait_drained();

    // Battery voltage and current share a channel: battery voltage wins. Zero
    // array gain, and an offset no reading can exceed.
    apply_setting(3'd3, 3'd6, 3'd6, '0, '1, '1, '1);
    repeat (2) push_item(3'd6, SAMPLE_MAX);
    push_item(3'd3, SAMPLE_MAX);
    push_item(3'd4, SAMPLE_MAX);
    wait_drained();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: apply_setting(acsc_pkg::RST_ARRAY_CH, acsc_pkg::RST_BATT_CH,
                         acsc_pkg::RST_CURR_CH, acsc_pkg::RST_ARRAY_GAIN,
                         acsc_pkg::RST_BATT_GAIN, acsc_pkg::RST_CURR_GAIN,
                         acsc_pkg::RST_CURR_OFFSET);
        1: apply_setting('0, '0, '0, '0, '0, '0, '0);
        2: apply_setting(3'd7, 3'd6, 3'd5, '1, '1, '1, '0);
        3: apply_setting(3'd1, 3'd2, 3'd3, 13'd1, 13'd1, 8'd1, '1);
        default: apply_setting(CH_W'($urandom_range(0, 7)), CH_W'($urandom_range(0, 7)),
                               CH_W'($urandom_range(0, 7)), VGAIN_W'($urandom),
                               VGAIN_W'($urandom), CGAIN_W'($urandom),
                               OFFSET_W'($urandom_range(0, 2047)));
      endcase
      add_random_items(PHASE_ITEMS);
      wait_drained();
    end

    if (mismatch_count == 0) begin
      $display("adc_channel_smoothing_scaler: match");
    end else begin
      $display("adc_channel_smoothing_scaler: mismatch");
    end
    $finish;
  end
endmodule
